FILE: rtl/core/v4a_pkg.sv
// shared types, command and status codes, saturation and rounding helpers
// used by every module of the vector alu; no dependencies
package v4a_pkg;

    localparam logic [3:0] CMD_ADD     = 4'd0;
    localparam logic [3:0] CMD_SUB     = 4'd1;
    localparam logic [3:0] CMD_NEG     = 4'd2;
    localparam logic [3:0] CMD_SCALE   = 4'd3;
    localparam logic [3:0] CMD_DIV     = 4'd4;
    localparam logic [3:0] CMD_DOT     = 4'd5;
    localparam logic [3:0] CMD_CROSS   = 4'd6;
    localparam logic [3:0] CMD_MAG     = 4'd7;
    localparam logic [3:0] CMD_NORM    = 4'd8;
    localparam logic [3:0] CMD_REFLECT = 4'd9;
    localparam logic [3:0] CMD_COLOUR  = 4'd10;
    localparam logic [3:0] CMD_EQUAL   = 4'd11;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIVZ = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    localparam logic [31:0] Q_ONE = 32'h0001_0000;

    localparam int SQ_STEPS  = 32;
    localparam int DIV_STEPS = 48;

    typedef struct packed {
        logic [3:0]       cmd;
        logic [3:0][31:0] a;
        logic [3:0][31:0] b;
        logic [31:0]      s;
    } in_t;

    typedef struct packed {
        logic [3:0]       cmd;
        logic [3:0][31:0] a;
        logic [31:0]      s;
        logic [3:0][31:0] r;
        logic [31:0]      rs;
        logic             sat;
        logic [64:0]      sq;
        logic [32:0]      mag;
    } ctl_t;

    typedef struct packed {
        logic [3:0][31:0] r;
        logic [31:0]      rs;
        logic [1:0]       status;
    } res_t;

    typedef struct packed {
        logic [31:0] v;
        logic        s;
    } satw_t;

    function automatic satw_t sat_wide(input logic signed [66:0] v);
        satw_t o;
        if (v > 67'sd2147483647)
        begin
            o.v = 32'h7FFF_FFFF;
            o.s = 1'b1;
        end
        else if (v < -67'sd2147483648)
        begin
            o.v = 32'h8000_0000;
            o.s = 1'b1;
        end
        else
        begin
            o.v = v[31:0];
            o.s = 1'b0;
        end
        return o;
    endfunction

    // round to nearest, ties toward plus infinity, then clamp
    function automatic satw_t round_sat(input logic signed [66:0] t);
        logic signed [66:0] u;
        u = (t + 67'sd32768) >>> 16;
        return sat_wide(u);
    endfunction

endpackage

FILE: rtl/core/v4a_if.sv
// valid/ready channel interfaces for the vector alu: request, result, config
// no dependencies
interface v4a_req_if;
    logic               valid;
    logic               ready;
    logic [3:0]         command;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] a_w;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic signed [31:0] b_w;
    logic signed [31:0] scalar_in;

    modport source (
        output valid, command, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, scalar_in,
        input  ready
    );
    modport sink (
        input  valid, command, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, scalar_in,
        output ready
    );
endinterface

interface v4a_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [31:0] r_z;
    logic signed [31:0] r_w;
    logic signed [31:0] r_scalar;
    logic [1:0]         status;

    modport source (
        output valid, r_x, r_y, r_z, r_w, r_scalar, status,
        input  ready
    );
    modport sink (
        input  valid, r_x, r_y, r_z, r_w, r_scalar, status,
        output ready
    );
endinterface

interface v4a_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] equal_tolerance;

    modport source (
        output valid, equal_tolerance,
        input  ready
    );
    modport sink (
        input  valid, equal_tolerance,
        output ready
    );
endinterface

FILE: rtl/core/v4a_arith.sv
// six-stage arithmetic front end: operand select, products, sums, rounding,
// reflect second pass; depends on v4a_pkg
module v4a_arith
    import v4a_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  in_t         din,
    input  logic [15:0] tol,
    output logic        out_valid,
    output ctl_t        dout
);

    typedef struct packed {
        logic [3:0]       cmd;
        logic [3:0][31:0] a;
        logic [3:0][31:0] b;
        logic [31:0]      s;
        logic [3:0][31:0] rsim;
        logic             ssat;
        logic             eq;
    } pass_t;

    logic [5:0] v_reg;

    in_t         st1_reg;
    logic [15:0] tol1_reg;

    pass_t              pass2_next, pass2_reg;
    logic signed [63:0] p2_next [0:5];
    logic signed [63:0] p2_reg  [0:5];

    pass_t              pass3_reg;
    logic signed [65:0] t3_next [0:3];
    logic signed [65:0] t3_reg  [0:3];
    logic signed [65:0] dot3_next, dot3_reg;

    pass_t       pass4_reg;
    satw_t       lane4_next [0:3];
    satw_t       lane4_reg  [0:3];
    satw_t       dot4_next, dot4_reg;
    logic [64:0] sq4_reg;

    pass_t              pass5_reg;
    satw_t              lane5_reg [0:3];
    satw_t              dot5_reg;
    logic [64:0]        sq5_reg;
    logic signed [63:0] q5_next [0:2];
    logic signed [63:0] q5_reg  [0:2];

    ctl_t dout_next, dout_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[4:0], in_valid};
        end
    end

    // stage 2: simple ops, equality, multiplier operands and products
    always_comb
    begin
        logic signed [32:0] sa;
        logic signed [32:0] sb;
        logic signed [32:0] w;
        logic signed [32:0] dd;
        logic [32:0]        ad;
        satw_t              sw;
        logic signed [31:0] mx [0:5];
        logic signed [31:0] my [0:5];
        sa = '0;
        sb = '0;
        w  = '0;
        dd = '0;
        ad = '0;
        sw = '0;
        pass2_next.cmd  = st1_reg.cmd;
        pass2_next.a    = st1_reg.a;
        pass2_next.b    = st1_reg.b;
        pass2_next.s    = st1_reg.s;
        pass2_next.rsim = '0;
        pass2_next.ssat = 1'b0;
        pass2_next.eq   = 1'b1;
        for (int i = 0; i < 4; i++)
        begin
            sa = {st1_reg.a[i][31], st1_reg.a[i]};
            sb = {st1_reg.b[i][31], st1_reg.b[i]};
            case (st1_reg.cmd)
                CMD_ADD: w = sa + sb;
                CMD_SUB: w = sa - sb;
                CMD_NEG: w = -sa;
                default: w = '0;
            endcase
            sw = sat_wide({{34{w[32]}}, w});
            pass2_next.rsim[i] = sw.v;
            pass2_next.ssat    = pass2_next.ssat | sw.s;
            dd = sa - sb;
            ad = dd[32] ? 33'(-dd) : 33'(dd);
            if (ad >= {17'b0, tol1_reg})
            begin
                pass2_next.eq = 1'b0;
            end
        end

        for (int j = 0; j < 6; j++)
        begin
            mx[j] = '0;
            my[j] = '0;
        end
        case (st1_reg.cmd)
            CMD_SCALE:
            begin
                for (int j = 0; j < 4; j++)
                begin
                    mx[j] = st1_reg.a[j];
                    my[j] = st1_reg.s;
                end
            end
            CMD_DOT, CMD_COLOUR, CMD_REFLECT:
            begin
                for (int j = 0; j < 4; j++)
                begin
                    mx[j] = st1_reg.a[j];
                    my[j] = st1_reg.b[j];
                end
            end
            CMD_MAG, CMD_NORM:
            begin
                for (int j = 0; j < 4; j++)
                begin
                    mx[j] = st1_reg.a[j];
                    my[j] = st1_reg.a[j];
                end
            end
            CMD_CROSS:
            begin
                mx[0] = st1_reg.a[1]; my[0] = st1_reg.b[2];
                mx[1] = st1_reg.a[2]; my[1] = st1_reg.b[0];
                mx[2] = st1_reg.a[0]; my[2] = st1_reg.b[1];
                mx[3] = st1_reg.a[2]; my[3] = st1_reg.b[1];
                mx[4] = st1_reg.a[0]; my[4] = st1_reg.b[2];
                mx[5] = st1_reg.a[1]; my[5] = st1_reg.b[0];
            end
            default:
            begin
            end
        endcase
        for (int j = 0; j < 6; j++)
        begin
            p2_next[j] = mx[j] * my[j];
        end
    end

    // stage 3: lane sums and four-term dot sum
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            t3_next[i] = 66'(p2_reg[i]);
        end
        if (pass2_reg.cmd == CMD_CROSS)
        begin
            for (int i = 0; i < 3; i++)
            begin
                t3_next[i] = 66'(p2_reg[i]) - 66'(p2_reg[i + 3]);
            end
        end
        dot3_next = 66'(p2_reg[0]) + 66'(p2_reg[1]) + 66'(p2_reg[2]) + 66'(p2_reg[3]);
    end

    // stage 4: rounding
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            lane4_next[i] = round_sat(67'(t3_reg[i]));
        end
        dot4_next = round_sat(67'(dot3_reg));
    end

    // stage 5: reflect products b * dot
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            q5_next[i] = $signed(pass4_reg.b[i]) * $signed(dot4_reg.v);
        end
    end

    // stage 6: reflect rounding and result select
    always_comb
    begin
        satw_t refl [0:2];
        for (int i = 0; i < 3; i++)
        begin
            refl[i] = round_sat((67'($signed(pass5_reg.a[i])) <<< 16)
                                - (67'(q5_reg[i]) <<< 1));
        end
        dout_next.cmd = pass5_reg.cmd;
        dout_next.a   = pass5_reg.a;
        dout_next.s   = pass5_reg.s;
        dout_next.r   = '0;
        dout_next.rs  = '0;
        dout_next.sat = 1'b0;
        dout_next.sq  = sq5_reg;
        dout_next.mag = '0;
        case (pass5_reg.cmd)
            CMD_ADD, CMD_SUB, CMD_NEG:
            begin
                dout_next.r   = pass5_reg.rsim;
                dout_next.sat = pass5_reg.ssat;
            end
            CMD_SCALE:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    dout_next.r[i] = lane5_reg[i].v;
                    dout_next.sat  = dout_next.sat | lane5_reg[i].s;
                end
            end
            CMD_DOT:
            begin
                dout_next.rs  = dot5_reg.v;
                dout_next.sat = dot5_reg.s;
            end
            CMD_CROSS, CMD_COLOUR:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    dout_next.r[i] = lane5_reg[i].v;
                    dout_next.sat  = dout_next.sat | lane5_reg[i].s;
                end
            end
            CMD_REFLECT:
            begin
                dout_next.sat = dot5_reg.s;
                for (int i = 0; i < 3; i++)
                begin
                    dout_next.r[i] = refl[i].v;
                    dout_next.sat  = dout_next.sat | refl[i].s;
                end
            end
            CMD_EQUAL:
            begin
                dout_next.rs = pass5_reg.eq ? Q_ONE : '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st1_reg   <= din;
            tol1_reg  <= tol;
            pass2_reg <= pass2_next;
            p2_reg    <= p2_next;
            pass3_reg <= pass2_reg;
            t3_reg    <= t3_next;
            dot3_reg  <= dot3_next;
            pass4_reg <= pass3_reg;
            lane4_reg <= lane4_next;
            dot4_reg  <= dot4_next;
            sq4_reg   <= dot3_reg[64:0];
            pass5_reg <= pass4_reg;
            lane5_reg <= lane4_reg;
            dot5_reg  <= dot4_reg;
            sq5_reg   <= sq4_reg;
            q5_reg    <= q5_next;
            dout_reg  <= dout_next;
        end
    end

    assign out_valid = v_reg[5];
    assign dout      = dout_reg;

endmodule

FILE: rtl/core/v4a_sqrt.sv
// pipelined square root of the sum of squares, one root bit per stage,
// rounded to nearest in a last stage; depends on v4a_pkg
module v4a_sqrt
    import v4a_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_valid,
    input  ctl_t din,
    output logic out_valid,
    output ctl_t dout
);

    logic [SQ_STEPS:0] v_reg;
    ctl_t              ctl_reg  [0:SQ_STEPS];
    logic [63:0]       rad_reg  [0:SQ_STEPS-1];
    logic [31:0]       root_reg [0:SQ_STEPS-1];
    logic [33:0]       rem_reg  [0:SQ_STEPS-1];
    ctl_t              fin_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[SQ_STEPS-1:0], in_valid};
        end
    end

    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_step
        ctl_t        c_in;
        logic [63:0] rad_in;
        logic [31:0] root_in;
        logic [33:0] rem_in;
        logic [35:0] t;
        logic [35:0] trial;
        logic [33:0] rem_next;
        logic [31:0] root_next;

        if (k == 0)
        begin : g_first
            assign c_in    = din;
            assign rad_in  = din.sq[63:0];
            assign root_in = '0;
            assign rem_in  = '0;
        end
        else
        begin : g_rest
            assign c_in    = ctl_reg[k-1];
            assign rad_in  = rad_reg[k-1];
            assign root_in = root_reg[k-1];
            assign rem_in  = rem_reg[k-1];
        end

        always_comb
        begin
            t     = {rem_in, rad_in[63:62]};
            trial = {2'b00, root_in, 2'b01};
            if (t >= trial)
            begin
                rem_next  = 34'(t - trial);
                root_next = {root_in[30:0], 1'b1};
            end
            else
            begin
                rem_next  = t[33:0];
                root_next = {root_in[30:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ctl_reg[k]  <= c_in;
                rad_reg[k]  <= {rad_in[61:0], 2'b00};
                root_reg[k] <= root_next;
                rem_reg[k]  <= rem_next;
            end
        end
    end

    // round to nearest; a sum of squares of 2^64 or more gives 2^32
    always_comb
    begin
        logic bump;
        bump = rem_reg[SQ_STEPS-1] > {2'b00, root_reg[SQ_STEPS-1]};
        fin_next = ctl_reg[SQ_STEPS-1];
        if (ctl_reg[SQ_STEPS-1].sq[64])
        begin
            fin_next.mag = 33'h1_0000_0000;
        end
        else
        begin
            fin_next.mag = {1'b0, root_reg[SQ_STEPS-1]} + 33'(bump);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctl_reg[SQ_STEPS] <= fin_next;
        end
    end

    assign out_valid = v_reg[SQ_STEPS];
    assign dout      = ctl_reg[SQ_STEPS];

endmodule

FILE: rtl/core/v4a_div.sv
// four-lane pipelined restoring divider, one quotient bit per stage, shared by
// divide and normalize, plus final status; depends on v4a_pkg
module v4a_div
    import v4a_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_valid,
    input  ctl_t din,
    output logic out_valid,
    output res_t dout
);

    typedef struct packed {
        logic [3:0][31:0] r;
        logic [31:0]      rs;
        logic             sat;
        logic             divz;
        logic             use_div;
        logic             norm;
        logic [3:0]       neg;
    } meta_t;

    logic [DIV_STEPS+1:0] v_reg;
    meta_t                meta_reg [0:DIV_STEPS];
    logic [32:0]          den_reg  [0:DIV_STEPS];
    logic [3:0][47:0]     n_reg    [0:DIV_STEPS];
    logic [3:0][32:0]     rem_reg  [0:DIV_STEPS];

    meta_t            meta_next;
    logic [32:0]      den_next;
    logic [3:0][47:0] num_next;
    res_t             res_next, res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[DIV_STEPS:0], in_valid};
        end
    end

    // operand setup: magnitudes, rounding offset, special cases
    always_comb
    begin
        logic        is_div;
        logic        is_norm;
        logic        den_neg;
        logic [31:0] s_abs;
        logic [31:0] a_abs;
        is_div  = din.cmd == CMD_DIV;
        is_norm = din.cmd == CMD_NORM;
        s_abs   = din.s[31] ? (~din.s + 32'd1) : din.s;
        den_neg = is_div & din.s[31];
        den_next = is_div ? {1'b0, s_abs} : din.mag;
        meta_next.r    = din.r;
        meta_next.rs   = din.rs;
        meta_next.sat  = din.sat;
        meta_next.divz = 1'b0;
        meta_next.norm = is_norm;
        if (din.cmd == CMD_MAG)
        begin
            if (din.mag > 33'h0_7FFF_FFFF)
            begin
                meta_next.rs  = 32'h7FFF_FFFF;
                meta_next.sat = 1'b1;
            end
            else
            begin
                meta_next.rs = din.mag[31:0];
            end
        end
        if ((is_div && din.s == '0) || (is_norm && din.mag == '0))
        begin
            meta_next.divz = 1'b1;
        end
        meta_next.use_div = (is_div | is_norm) & ~meta_next.divz;
        a_abs = '0;
        for (int l = 0; l < 4; l++)
        begin
            a_abs = din.a[l][31] ? (~din.a[l] + 32'd1) : din.a[l];
            num_next[l]      = {a_abs, 16'b0} + 48'(den_next >> 1);
            meta_next.neg[l] = din.a[l][31] ^ den_neg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            meta_reg[0] <= meta_next;
            den_reg[0]  <= den_next;
            n_reg[0]    <= num_next;
            rem_reg[0]  <= '0;
        end
    end

    for (genvar k = 1; k <= DIV_STEPS; k++)
    begin : g_step
        logic [3:0][33:0] t;
        logic [3:0][32:0] rem_next;
        logic [3:0][47:0] n_next;

        always_comb
        begin
            for (int l = 0; l < 4; l++)
            begin
                t[l] = {rem_reg[k-1][l], n_reg[k-1][l][47]};
                if (t[l] >= {1'b0, den_reg[k-1]})
                begin
                    rem_next[l] = 33'(t[l] - {1'b0, den_reg[k-1]});
                    n_next[l]   = {n_reg[k-1][l][46:0], 1'b1};
                end
                else
                begin
                    rem_next[l] = t[l][32:0];
                    n_next[l]   = {n_reg[k-1][l][46:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                meta_reg[k] <= meta_reg[k-1];
                den_reg[k]  <= den_reg[k-1];
                n_reg[k]    <= n_next;
                rem_reg[k]  <= rem_next;
            end
        end
    end

    // sign, clamp and status
    always_comb
    begin
        meta_t       m;
        logic [47:0] q;
        logic        sat;
        m   = meta_reg[DIV_STEPS];
        q   = '0;
        sat = m.sat;
        res_next.r  = m.r;
        res_next.rs = m.rs;
        if (m.use_div)
        begin
            for (int l = 0; l < 4; l++)
            begin
                q = n_reg[DIV_STEPS][l];
                if (m.norm && l == 3)
                begin
                    res_next.r[l] = '0;
                end
                else if (m.neg[l])
                begin
                    if (q > 48'h0000_8000_0000)
                    begin
                        sat           = 1'b1;
                        res_next.r[l] = 32'h8000_0000;
                    end
                    else
                    begin
                        res_next.r[l] = ~q[31:0] + 32'd1;
                    end
                end
                else if (q > 48'h0000_7FFF_FFFF)
                begin
                    sat           = 1'b1;
                    res_next.r[l] = 32'h7FFF_FFFF;
                end
                else
                begin
                    res_next.r[l] = q[31:0];
                end
            end
        end
        if (m.divz)
        begin
            res_next.r  = '0;
            res_next.rs = '0;
        end
        res_next.status = m.divz ? ST_DIVZ : (sat ? ST_SAT : ST_OK);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = v_reg[DIV_STEPS+1];
    assign dout      = res_reg;

endmodule

FILE: rtl/core/vector4_fixed_point_alu.sv
// q16.16 four-component vector alu, top level; uses v4a_pkg, v4a_if,
// v4a_arith, v4a_sqrt, v4a_div
// items pass through the arithmetic front end, the square root (32 root-bit
// stages) and the divider (48 quotient-bit stages); one item per cycle
// unless stalled: the whole pipeline holds while a result waits on rsp.ready
// reset clears all valid bits and sets equal_tolerance to 7
module vector4_fixed_point_alu
    import v4a_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    v4a_req_if.sink     req,
    v4a_rsp_if.source   rsp,
    v4a_cfg_if.sink     cfg
);

    logic [15:0] tol_reg;
    logic        en;
    in_t         din;
    logic        ar_valid, sq_valid, dv_valid;
    ctl_t        ar_ctl, sq_ctl;
    res_t        res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= 16'd7;
        end
        else if (cfg.valid)
        begin
            tol_reg <= cfg.equal_tolerance;
        end
    end

    assign cfg.ready = 1'b1;
    assign en        = ~dv_valid | rsp.ready;
    assign req.ready = en;

    assign din.cmd  = req.command;
    assign din.a[0] = req.a_x;
    assign din.a[1] = req.a_y;
    assign din.a[2] = req.a_z;
    assign din.a[3] = req.a_w;
    assign din.b[0] = req.b_x;
    assign din.b[1] = req.b_y;
    assign din.b[2] = req.b_z;
    assign din.b[3] = req.b_w;
    assign din.s    = req.scalar_in;

    v4a_arith u_arith (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (req.valid),
        .din       (din),
        .tol       (tol_reg),
        .out_valid (ar_valid),
        .dout      (ar_ctl)
    );

    v4a_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (ar_valid),
        .din       (ar_ctl),
        .out_valid (sq_valid),
        .dout      (sq_ctl)
    );

    v4a_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .din       (sq_ctl),
        .out_valid (dv_valid),
        .dout      (res)
    );

    assign rsp.valid    = dv_valid;
    assign rsp.r_x      = res.r[0];
    assign rsp.r_y      = res.r[1];
    assign rsp.r_z      = res.r[2];
    assign rsp.r_w      = res.r[3];
    assign rsp.r_scalar = res.rs;
    assign rsp.status   = res.status;

endmodule
